FILE: rtl/ovrseek_pkg.sv
package ovrseek_pkg;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_FIND = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_READ,
      ST_ADD_WRITE,
      ST_FIND_START,
      ST_FIND_WALK
   } state_type;

   typedef struct packed {
      logic [0:0]  command;
      logic [31:0] new_handle;
      logic [15:0] new_size;
      logic [19:0] seek_offset;
   } req_type;

   typedef struct packed {
      logic [0:0]  hit;
      logic [3:0]  slot;
      logic [31:0] found_handle;
      logic [15:0] found_size;
      logic [15:0] byte_offset;
      logic [31:0] evicted_handle;
   } rsp_type;

endpackage

FILE: rtl/ovrseek_store.sv
module ovrseek_store
   import ovrseek_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [31:0]              wr_handle,
   input  logic [15:0]              wr_size,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [31:0]              rd_handle,
   output logic [15:0]              rd_size
);

   logic [31:0]      handle_mem [DEPTH];
   logic [15:0]      size_mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;
   logic [31:0]      rd_handle_ff;
   logic [15:0]      rd_size_ff;
   logic             rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         handle_mem[wr_addr] <= wr_handle;
         size_mem[wr_addr]   <= wr_size;
      end
      rd_handle_ff <= handle_mem[rd_addr];
      rd_size_ff   <= size_mem[rd_addr];
   end

   // never-written entries read as zero
   assign rd_handle = rd_valid_ff ? rd_handle_ff : 32'd0;
   assign rd_size   = rd_valid_ff ? rd_size_ff : 16'd0;

endmodule

FILE: rtl/overwriting_ring_with_offset_seek.sv
// channel   ports                         transfer
// request   start, busy, req_data         taken when start high and busy low
// result    rsp_valid, rsp_data           one-cycle strobe, always taken
//
// an add steps through ADD_READ and ADD_WRITE, and its result strobe is registered
// a find walks from the oldest entry, at most DEPTH entries, one entry
// per cycle through the single compare-subtract unit and the store read port
// busy stays high from acceptance until the cycle before the result strobe
// synchronous reset clears pointers, full flag and entry valid bits at once
// the result side cannot stall: each result shows for exactly one cycle
module overwriting_ring_with_offset_seek
   import ovrseek_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             full_ff, full_in;
   logic [PTR_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [19:0]      rem_ff, rem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [CNT_W-1:0] count;
   logic             mem_wr_en;
   logic [PTR_W-1:0] mem_rd_addr;
   logic [31:0]      mem_rd_handle;
   logic [15:0]      mem_rd_size;
   logic             size_hit;
   logic [PTR_W+3:0] pos_ext;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   assign size_hit = ({4'd0, mem_rd_size} > rem_ff);
   assign pos_ext  = {4'd0, pos_ff};

   always_comb begin
      if (full_ff) begin
         count = CNT_W'(DEPTH);
      end else if (wr_ptr_ff >= rd_ptr_ff) begin
         count = CNT_W'(wr_ptr_ff) - CNT_W'(rd_ptr_ff);
      end else begin
         count = CNT_W'(wr_ptr_ff) + CNT_W'(DEPTH) - CNT_W'(rd_ptr_ff);
      end
   end

   ovrseek_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (mem_wr_en),
      .wr_addr   (wr_ptr_ff),
      .wr_handle (req_ff.new_handle),
      .wr_size   (req_ff.new_size),
      .rd_addr   (mem_rd_addr),
      .rd_handle (mem_rd_handle),
      .rd_size   (mem_rd_size)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (cmd_type'(req_data.command) == CMD_ADD) begin
                  state_in = ST_ADD_READ;
               end else begin
                  state_in = ST_FIND_START;
               end
            end
         end
         ST_ADD_READ: begin
            state_in = ST_ADD_WRITE;
         end
         ST_ADD_WRITE: begin
            state_in = ST_IDLE;
         end
         ST_FIND_START: begin
            if (left_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_FIND_WALK;
            end
         end
         ST_FIND_WALK: begin
            if (size_hit || left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_in       = req_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      full_in      = full_ff;
      pos_in       = pos_ff;
      left_in      = left_ff;
      rem_in       = rem_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_wr_en    = 1'b0;
      mem_rd_addr  = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in  = req_data;
               pos_in  = rd_ptr_ff;
               rem_in  = req_data.seek_offset;
               left_in = count;
            end
         end
         ST_ADD_READ: begin
            mem_rd_addr = wr_ptr_ff;
         end
         ST_ADD_WRITE: begin
            mem_wr_en             = 1'b1;
            rsp_in                = '0;
            rsp_in.evicted_handle = mem_rd_handle;
            rsp_valid_in          = 1'b1;
            wr_ptr_in             = ptr_next(wr_ptr_ff);
            if (full_ff) begin
               rd_ptr_in = ptr_next(rd_ptr_ff);
            end else if (ptr_next(wr_ptr_ff) == rd_ptr_ff) begin
               full_in = 1'b1;
            end
         end
         ST_FIND_START: begin
            mem_rd_addr = pos_ff;
            if (left_ff == '0) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
            end
         end
         ST_FIND_WALK: begin
            // prefetch the next slot while comparing the current one
            mem_rd_addr = ptr_next(pos_ff);
            if (size_hit) begin
               rsp_in              = '0;
               rsp_in.hit          = 1'b1;
               rsp_in.slot         = pos_ext[3:0];
               rsp_in.found_handle = mem_rd_handle;
               rsp_in.found_size   = mem_rd_size;
               rsp_in.byte_offset  = rem_ff[15:0];
               rsp_valid_in        = 1'b1;
            end else if (left_ff == CNT_W'(1)) begin
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
            end else begin
               rem_in  = rem_ff - {4'd0, mem_rd_size};
               pos_in  = ptr_next(pos_ff);
               left_in = left_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pos_ff  <= pos_in;
      left_ff <= left_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_done_gives_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_full_pointers_meet: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("full ring with pointers apart");

   a_hit_has_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.evicted_handle == 32'd0))
      else $error("find result carries an evicted handle");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND_WALK) |-> (pos_ff <= PTR_W'(DEPTH - 1)))
      else $error("walk position out of ring");

endmodule

FILE: test/tb_overwriting_ring_with_offset_seek.sv
module tb_overwriting_ring_with_offset_seek
   import ovrseek_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int RANDOM_REQUESTS = 1150;
   localparam rsp_type NO_RESULT = '0;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } plan_row_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   // predictor copy of the ring
   logic [31:0] held_handle[DEPTH];
   logic [15:0] held_size[DEPTH];
   int unsigned in_ptr;
   int unsigned out_ptr;
   bit          is_full;

   rsp_type      pending_outcomes[$];
   plan_row_type directed_plan[$];
   int unsigned  mismatches;
   int unsigned  burst_left;
   rsp_type      got_rsp;
   rsp_type      want_rsp;

   overwriting_ring_with_offset_seek #(
      .DEPTH(DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   task automatic note_mismatch(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
      $display("mismatch %s: expected %h got %h at %0t", what, want_v, got_v, $realtime);
      mismatches++;
   endtask

   // add writes at the in pointer; find walks from the oldest entry
   function automatic rsp_type ring_outcome(input req_type r);
      rsp_type     o;
      int unsigned walk;
      int unsigned pos;
      int unsigned left;
      bit          found;
      o = NO_RESULT;
      found = 1'b0;
      if (cmd_type'(r.command) == CMD_ADD) begin
         o.evicted_handle = held_handle[in_ptr];
         held_handle[in_ptr] = r.new_handle;
         held_size[in_ptr] = r.new_size;
         in_ptr = (in_ptr + 1) % DEPTH;
         if (is_full) begin
            out_ptr = (out_ptr + 1) % DEPTH;
         end else if (in_ptr == out_ptr) begin
            is_full = 1'b1;
         end
      end else begin
         walk = is_full ? DEPTH : (in_ptr + DEPTH - out_ptr) % DEPTH;
         pos = out_ptr;
         left = r.seek_offset;
         for (int i = 0; i < walk && !found; i++) begin
            if (held_size[pos] > left) begin
               found = 1'b1;
               o.hit = 1'b1;
               o.slot = 4'(pos);
               o.found_handle = held_handle[pos];
               o.found_size = held_size[pos];
               o.byte_offset = 16'(left);
            end else begin
               left = left - held_size[pos];
               pos = (pos + 1) % DEPTH;
            end
         end
      end
      return o;
   endfunction

   function automatic int unsigned stored_bytes();
      int unsigned walk;
      int unsigned total;
      total = 0;
      walk = is_full ? DEPTH : (in_ptr + DEPTH - out_ptr) % DEPTH;
      for (int i = 0; i < walk; i++) begin
         total = total + held_size[(out_ptr + i) % DEPTH];
      end
      return total;
   endfunction

   function automatic req_type make_req(input cmd_type c, input logic [31:0] h,
                                        input logic [15:0] s, input logic [19:0] off);
      req_type r;
      r.command = c;
      r.new_handle = h;
      r.new_size = s;
      r.seek_offset = off;
      return r;
   endfunction

   task automatic plan_row(input req_type r, input bit typed, input rsp_type want);
      plan_row_type row;
      row.req = r;
      row.typed = typed;
      row.want = want;
      directed_plan.push_back(row);
   endtask

   function automatic req_type random_request();
      req_type     r;
      int unsigned total;
      int unsigned pick;
      r.command = ($urandom_range(0, 99) < 50) ? CMD_FIND : CMD_ADD;
      pick = $urandom_range(0, 19);
      r.new_handle = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
      pick = $urandom_range(0, 9);
      case (pick)
         0: r.new_size = 16'h0;
         1: r.new_size = 16'hFFFF;
         2, 3: r.new_size = 16'($urandom);
         default: r.new_size = 16'($urandom_range(1, 300));
      endcase
      total = stored_bytes();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         r.seek_offset = 20'($urandom);
      end else if (pick == 1 || total == 0) begin
         r.seek_offset = 20'(total);
      end else begin
         r.seek_offset = 20'($urandom_range(0, total - 1));
      end
      return r;
   endfunction

   // hold start until the request is taken, then maybe pause
   task automatic issue_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type predicted;
      int unsigned gap;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = ring_outcome(r);
      pending_outcomes.push_back(typed ? want : predicted);
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got_rsp = rsp_data;
         if (pending_outcomes.size() == 0) begin
            note_mismatch("unexpected result", 32'h0, 32'h0);
         end else begin
            want_rsp = pending_outcomes.pop_front();
            if (got_rsp.hit !== want_rsp.hit)
               note_mismatch("hit", 32'(want_rsp.hit), 32'(got_rsp.hit));
            if (got_rsp.slot !== want_rsp.slot)
               note_mismatch("slot", 32'(want_rsp.slot), 32'(got_rsp.slot));
            if (got_rsp.found_handle !== want_rsp.found_handle)
               note_mismatch("found_handle", want_rsp.found_handle, got_rsp.found_handle);
            if (got_rsp.found_size !== want_rsp.found_size)
               note_mismatch("found_size", 32'(want_rsp.found_size),
                             32'(got_rsp.found_size));
            if (got_rsp.byte_offset !== want_rsp.byte_offset)
               note_mismatch("byte_offset", 32'(want_rsp.byte_offset),
                             32'(got_rsp.byte_offset));
            if (got_rsp.evicted_handle !== want_rsp.evicted_handle)
               note_mismatch("evicted_handle", want_rsp.evicted_handle,
                             got_rsp.evicted_handle);
         end
      end
   end

   initial begin
      #500000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      rsp_type     first_hit;
      int unsigned wait_cycles;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      mismatches = 0;
      burst_left = $urandom_range(0, 6);
      for (int i = 0; i < DEPTH; i++) begin
         held_handle[i] = '0;
         held_size[i] = '0;
      end
      in_ptr = 0;
      out_ptr = 0;
      is_full = 1'b0;

      // empty ring, extremes, zero-size skip, partial and full walks, overwrite
      first_hit = NO_RESULT;
      first_hit.hit = 1'b1;
      first_hit.found_handle = 32'hFFFF_FFFF;
      first_hit.found_size = 16'hFFFF;
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h0), 1'b1, NO_RESULT);
      plan_row(make_req(CMD_FIND, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF), 1'b1, NO_RESULT);
      plan_row(make_req(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF), 1'b1, NO_RESULT);
      plan_row(make_req(CMD_ADD, 32'h0, 16'h0, 20'h0), 1'b1, NO_RESULT);
      plan_row(make_req(CMD_ADD, 32'h5A5A_A5A5, 16'h1, 20'h0), 1'b1, NO_RESULT);
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h0), 1'b1, first_hit);
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h0FFFE), 1'b0, NO_RESULT);
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h0FFFF), 1'b0, NO_RESULT);
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h10000), 1'b1, NO_RESULT);
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'hFFFFF), 1'b1, NO_RESULT);
      for (int i = 0; i < 12; i++) begin
         plan_row(make_req(CMD_ADD, 32'h1000_0000 + i, 16'(7 * i + 3), 20'h0),
                  1'b1, NO_RESULT);
      end
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h10005), 1'b0, NO_RESULT);
      plan_row(make_req(CMD_ADD, 32'hC0DE_0001, 16'h8000, 20'h0), 1'b1, NO_RESULT);
      first_hit = NO_RESULT;
      first_hit.evicted_handle = 32'hFFFF_FFFF;
      plan_row(make_req(CMD_ADD, 32'hC0DE_0002, 16'h0004, 20'h0), 1'b1, first_hit);
      plan_row(make_req(CMD_FIND, 32'h0, 16'h0, 20'h0), 1'b0, NO_RESULT);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_plan[i]) begin
         issue_request(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
      end
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         issue_request(random_request(), 1'b0, NO_RESULT);
      end
      start <= 1'b0;

      for (wait_cycles = 0; pending_outcomes.size() != 0 && wait_cycles < 1000;
           wait_cycles++) begin
         @(posedge clock);
      end
      repeat (DEPTH + 4) @(posedge clock);
      while (pending_outcomes.size() != 0) begin
         want_rsp = pending_outcomes.pop_front();
         note_mismatch("missing result", 32'(want_rsp.hit), 32'h0);
      end

      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
